[rtl/core/rti_pkg.sv]
package rti_pkg;

  localparam int DIR_W     = 18;
  localparam int TAG_W     = 16;
  localparam int DIST_W    = 31;
  localparam int BARY_W    = 17;
  localparam int T_SHIFT   = 16;
  localparam int QUO_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 18'sd65536;
  localparam logic [BARY_W-1:0]       BARY_ONE    = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } cfg_reg_t;

  // sideband that rides alongside the arithmetic
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [TAG_W-1:0] tag;
  } rti_side_t;

endpackage

[rtl/core/rti_if.sv]
interface rti_in_if #(parameter int CW = 32) ();
  import rti_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CW-1:0]    v0_x, v0_y, v0_z;
  logic signed [CW-1:0]    v1_x, v1_y, v1_z;
  logic signed [CW-1:0]    v2_x, v2_y, v2_z;
  logic        [TAG_W-1:0] tri_tag;
  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, tri_tag, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, tri_tag, output ready);
endinterface

interface rti_out_if ();
  import rti_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] hit_distance;
  logic [BARY_W-1:0] bary_u;
  logic [BARY_W-1:0] bary_v;
  logic [TAG_W-1:0]  tag_out;
  modport source (output valid, hit, hit_distance, bary_u, bary_v, tag_out, input ready);
  modport sink (input valid, hit, hit_distance, bary_u, bary_v, tag_out, output ready);
endinterface

interface rti_cfg_if #(parameter int DW = 32) ();
  import rti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DW-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rti_mul.sv]
module rti_mul #(
  parameter int WA = 33,
  parameter int WB = 52
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);
  localparam int NC = (WB + 31) / 32;
  localparam int BX = NC * 32;
  localparam int PW = WA + WB;

  logic signed [BX-1:0]   bx;
  logic signed [WA+32:0]  pp_r [NC];
  logic signed [PW-1:0]   p_r;
  logic signed [PW-1:0]   sum_nxt;

  assign bx = BX'(b);

  // one partial product per 32-bit slice of b, only the top slice is signed
  for (genvar c = 0; c < NC; c++) begin : g_slice
    if (c == NC - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (en) pp_r[c] <= (WA+33)'(a * $signed(bx[32*c +: 32]));
      end
    end else begin : g_low
      always_ff @(posedge clk) begin
        if (en) pp_r[c] <= (WA+33)'(a * $signed({1'b0, bx[32*c +: 32]}));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < NC; c++) begin
      sum_nxt = sum_nxt + (PW'(pp_r[c]) <<< (32 * c));
    end
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= sum_nxt;
  end

  assign p = p_r;
endmodule

[rtl/core/rti_front.sv]
module rti_front #(
  parameter int CW = 32,
  parameter int EW = 33,
  parameter int HW = 52,
  parameter int QW = 67
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  rti_pkg::rti_side_t                side_i,
  input  logic signed [CW-1:0]              v0 [3],
  input  logic signed [CW-1:0]              v1 [3],
  input  logic signed [CW-1:0]              v2 [3],
  input  logic signed [CW-1:0]              org [3],
  input  logic signed [rti_pkg::DIR_W-1:0]  dir [3],
  output rti_pkg::rti_side_t                side_o,
  output logic signed [EW-1:0]              e1_o [3],
  output logic signed [EW-1:0]              e2_o [3],
  output logic signed [EW-1:0]              s_o [3],
  output logic signed [rti_pkg::DIR_W-1:0]  dir_o [3],
  output logic signed [HW-1:0]              h_o [3],
  output logic signed [QW-1:0]              q_o [3]
);
  import rti_pkg::*;

  rti_side_t side_r [3];

  logic signed [EW-1:0]       e1a_r [3], e2a_r [3], sa_r [3];
  logic signed [DIR_W-1:0]    da_r [3];
  logic signed [EW-1:0]       e1b_r [3], e2b_r [3], sb_r [3];
  logic signed [DIR_W-1:0]    db_r [3];
  logic signed [DIR_W+EW-1:0] hpa_r [3], hpb_r [3];
  logic signed [2*EW-1:0]     qpa_r [3], qpb_r [3];
  logic signed [EW-1:0]       e1c_r [3], e2c_r [3], sc_r [3];
  logic signed [DIR_W-1:0]    dc_r [3];
  logic signed [HW-1:0]       h_r [3];
  logic signed [QW-1:0]       q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) side_r[i] <= '0;
    end else if (en) begin
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        // edges and origin offset
        e1a_r[i] <= EW'(v1[i]) - EW'(v0[i]);
        e2a_r[i] <= EW'(v2[i]) - EW'(v0[i]);
        sa_r[i]  <= EW'(org[i]) - EW'(v0[i]);
        da_r[i]  <= dir[i];
        // cross product terms
        hpa_r[i] <= (DIR_W+EW)'(da_r[J] * e2a_r[K]);
        hpb_r[i] <= (DIR_W+EW)'(da_r[K] * e2a_r[J]);
        qpa_r[i] <= (2*EW)'(sa_r[J] * e1a_r[K]);
        qpb_r[i] <= (2*EW)'(sa_r[K] * e1a_r[J]);
        e1b_r[i] <= e1a_r[i];
        e2b_r[i] <= e2a_r[i];
        sb_r[i]  <= sa_r[i];
        db_r[i]  <= da_r[i];
        h_r[i]   <= HW'(hpa_r[i]) - HW'(hpb_r[i]);
        q_r[i]   <= QW'(qpa_r[i]) - QW'(qpb_r[i]);
        e1c_r[i] <= e1b_r[i];
        e2c_r[i] <= e2b_r[i];
        sc_r[i]  <= sb_r[i];
        dc_r[i]  <= db_r[i];
      end
    end
    assign e1_o[i]  = e1c_r[i];
    assign e2_o[i]  = e2c_r[i];
    assign s_o[i]   = sc_r[i];
    assign dir_o[i] = dc_r[i];
    assign h_o[i]   = h_r[i];
    assign q_o[i]   = q_r[i];
  end

  assign side_o = side_r[2];
endmodule

[rtl/core/rti_dot.sv]
module rti_dot #(
  parameter int EW = 33,
  parameter int HW = 52,
  parameter int QW = 67,
  parameter int NW = 102
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  rti_pkg::rti_side_t                side_i,
  input  logic signed [EW-1:0]              e1 [3],
  input  logic signed [EW-1:0]              e2 [3],
  input  logic signed [EW-1:0]              s [3],
  input  logic signed [rti_pkg::DIR_W-1:0]  dir [3],
  input  logic signed [HW-1:0]              h [3],
  input  logic signed [QW-1:0]              q [3],
  output rti_pkg::rti_side_t                side_o,
  output logic [NW-1:0]                     det_o,
  output logic [NW-1:0]                     un_o,
  output logic [NW-1:0]                     vn_o,
  output logic [NW-1:0]                     tn_o
);
  import rti_pkg::*;

  logic signed [EW+HW-1:0]    pd [3], pu [3];
  logic signed [DIR_W+QW-1:0] pv [3];
  logic signed [EW+QW-1:0]    pt [3];

  rti_side_t side_r [5];
  rti_side_t side_nxt;

  logic signed [NW-1:0] det3_r, un3_r, vn3_r, tn3_r;
  logic signed [NW-1:0] det4_r, un4_r, vn4_r, tn4_r;
  logic                 nz4_r;
  logic [NW-1:0]        det5_r, un5_r, vn5_r, tn5_r;
  logic signed [NW:0]   uv_sum;
  logic                 ok;
  logic                 neg;

  for (genvar i = 0; i < 3; i++) begin : g_mul
    rti_mul #(.WA(EW), .WB(HW)) u_det (.clk, .en, .a(e1[i]), .b(h[i]), .p(pd[i]));
    rti_mul #(.WA(EW), .WB(HW)) u_un (.clk, .en, .a(s[i]), .b(h[i]), .p(pu[i]));
    rti_mul #(.WA(DIR_W), .WB(QW)) u_vn (.clk, .en, .a(dir[i]), .b(q[i]), .p(pv[i]));
    rti_mul #(.WA(EW), .WB(QW)) u_tn (.clk, .en, .a(e2[i]), .b(q[i]), .p(pt[i]));
  end

  assign neg = det3_r[NW-1];

  // a negative determinant flips the sign of every numerator
  assign uv_sum = {un4_r[NW-1], un4_r} + {vn4_r[NW-1], vn4_r};
  assign ok = nz4_r && !un4_r[NW-1] && (det4_r >= un4_r) && !vn4_r[NW-1]
              && (uv_sum <= {det4_r[NW-1], det4_r}) && !tn4_r[NW-1] && (tn4_r != '0);

  always_comb begin
    side_nxt     = side_r[3];
    side_nxt.hit = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) side_r[i] <= '0;
    end else if (en) begin
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      side_r[3] <= side_r[2];
      side_r[4] <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det3_r <= NW'(pd[0]) + NW'(pd[1]) + NW'(pd[2]);
      un3_r  <= NW'(pu[0]) + NW'(pu[1]) + NW'(pu[2]);
      vn3_r  <= NW'(pv[0]) + NW'(pv[1]) + NW'(pv[2]);
      tn3_r  <= NW'(pt[0]) + NW'(pt[1]) + NW'(pt[2]);
      det4_r <= neg ? -det3_r : det3_r;
      un4_r  <= neg ? -un3_r : un3_r;
      vn4_r  <= neg ? -vn3_r : vn3_r;
      tn4_r  <= neg ? -tn3_r : tn3_r;
      nz4_r  <= (det3_r != '0);
      det5_r <= det4_r;
      un5_r  <= un4_r;
      vn5_r  <= vn4_r;
      tn5_r  <= tn4_r;
    end
  end

  assign side_o = side_r[4];
  assign det_o  = det5_r;
  assign un_o   = un5_r;
  assign vn_o   = vn5_r;
  assign tn_o   = tn5_r;
endmodule

[rtl/core/rti_div.sv]
module rti_div #(
  parameter int NW = 102
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NW-1:0]              n,
  input  logic [NW-1:0]              d,
  output logic [rti_pkg::QUO_W-1:0]  quo
);
  import rti_pkg::*;

  localparam int RW = NW + QUO_W + 1;

  logic [RW-1:0]    rem_r [QUO_W+1];
  logic [NW-1:0]    d_r [QUO_W];
  logic [QUO_W-1:0] q_r [QUO_W+1];
  logic             sat_r [QUO_W+1];

  // front stage: scale numerator, flag quotients that do not fit
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(n) << T_SHIFT;
      d_r[0]   <= d;
      q_r[0]   <= '0;
      sat_r[0] <= (RW'(n) << T_SHIFT) >= (RW'(d) << QUO_W);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
    localparam int B = QUO_W - k;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(d_r[k-1]) << B;
    assign take = rem_r[k-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? rem_r[k-1] - dsh : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (QUO_W'(take) << B);
        sat_r[k] <= sat_r[k-1];
      end
    end
    if (k < QUO_W) begin : g_d
      always_ff @(posedge clk) begin
        if (en) d_r[k] <= d_r[k-1];
      end
    end
  end

  assign quo = sat_r[QUO_W] ? '1 : q_r[QUO_W];
endmodule

[rtl/core/ray_triangle_intersection.sv]
// Ray/triangle intersection, fixed point, one triangle per beat.
// in_ch carries three Q16.16 vertices and a tag; out_ch returns hit, t in Q15.16
// (saturated), barycentric u and v in Q1.16 and the tag. A miss returns zeros
// with the tag. The ray (origin Q16.16, direction Q1.16) sits in registers
// written over cfg_ch, index 0..5 = origin x,y,z then direction x,y,z; other
// indexes are dropped. cfg_ch is always ready; write it only while no triangle
// is in flight.
// An accepted input beat passes the edges and cross products, then the dot
// products, sign fix-up and range tests, then the three restoring dividers,
// one quotient bit a stage, before it leaves as its output beat.
// Throughput is one triangle per cycle; the whole pipeline advances on one
// enable, so a new beat enters every cycle while the output is empty or taken.
// When out_ch.ready is low with a result waiting, every stage holds and
// in_ch.ready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the ray to origin zero,
// direction +z.
module ray_triangle_intersection #(
  parameter int COORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  rti_in_if.sink           in_ch,
  rti_out_if.source        out_ch,
  rti_cfg_if.sink          cfg_ch
);
  import rti_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int EW      = CW + 1;
  localparam int HW      = DIR_W + EW + 1;
  localparam int QW      = 2 * EW + 1;
  localparam int NW      = EW + QW + 2;
  localparam int DIV_LAT = QUO_W + 1;

  logic signed [CW-1:0]    org_r [3];
  logic signed [DIR_W-1:0] dir_r [3];

  logic                    en;
  rti_side_t               side_in;
  rti_side_t               side_f, side_d;
  rti_side_t               side_dly_r [DIV_LAT];
  logic signed [CW-1:0]    v0_w [3], v1_w [3], v2_w [3];
  logic signed [EW-1:0]    e1_w [3], e2_w [3], s_w [3];
  logic signed [DIR_W-1:0] dir_w [3];
  logic signed [HW-1:0]    h_w [3];
  logic signed [QW-1:0]    q_w [3];
  logic [NW-1:0]           det_w, un_w, vn_w, tn_w;
  logic [QUO_W-1:0]        qt, qu, qv;

  // ray registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) org_r[i] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_ORG_X: org_r[0] <= cfg_ch.data[CW-1:0];
        REG_ORG_Y: org_r[1] <= cfg_ch.data[CW-1:0];
        REG_ORG_Z: org_r[2] <= cfg_ch.data[CW-1:0];
        REG_DIR_X: dir_r[0] <= cfg_ch.data[DIR_W-1:0];
        REG_DIR_Y: dir_r[1] <= cfg_ch.data[DIR_W-1:0];
        REG_DIR_Z: dir_r[2] <= cfg_ch.data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // single pipeline enable
  assign en          = !side_dly_r[DIV_LAT-1].vld || out_ch.ready;
  assign in_ch.ready = en;

  assign side_in = '{vld: in_ch.valid, hit: 1'b0, tag: in_ch.tri_tag};

  assign v0_w[0] = in_ch.v0_x;
  assign v0_w[1] = in_ch.v0_y;
  assign v0_w[2] = in_ch.v0_z;
  assign v1_w[0] = in_ch.v1_x;
  assign v1_w[1] = in_ch.v1_y;
  assign v1_w[2] = in_ch.v1_z;
  assign v2_w[0] = in_ch.v2_x;
  assign v2_w[1] = in_ch.v2_y;
  assign v2_w[2] = in_ch.v2_z;

  rti_front #(.CW(CW), .EW(EW), .HW(HW), .QW(QW)) u_front (
    .clk, .rst_n, .en,
    .side_i(side_in), .v0(v0_w), .v1(v1_w), .v2(v2_w), .org(org_r), .dir(dir_r),
    .side_o(side_f), .e1_o(e1_w), .e2_o(e2_w), .s_o(s_w), .dir_o(dir_w),
    .h_o(h_w), .q_o(q_w)
  );

  rti_dot #(.EW(EW), .HW(HW), .QW(QW), .NW(NW)) u_dot (
    .clk, .rst_n, .en,
    .side_i(side_f), .e1(e1_w), .e2(e2_w), .s(s_w), .dir(dir_w), .h(h_w), .q(q_w),
    .side_o(side_d), .det_o(det_w), .un_o(un_w), .vn_o(vn_w), .tn_o(tn_w)
  );

  rti_div #(.NW(NW)) u_div_t (.clk, .en, .n(tn_w), .d(det_w), .quo(qt));
  rti_div #(.NW(NW)) u_div_u (.clk, .en, .n(un_w), .d(det_w), .quo(qu));
  rti_div #(.NW(NW)) u_div_v (.clk, .en, .n(vn_w), .d(det_w), .quo(qv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) side_dly_r[i] <= '0;
    end else if (en) begin
      side_dly_r[0] <= side_d;
      for (int i = 1; i < DIV_LAT; i++) side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  assign out_ch.valid        = side_dly_r[DIV_LAT-1].vld;
  assign out_ch.hit          = side_dly_r[DIV_LAT-1].hit;
  assign out_ch.tag_out      = side_dly_r[DIV_LAT-1].tag;
  assign out_ch.hit_distance = out_ch.hit ? DIST_W'(qt) : '0;
  assign out_ch.bary_u       = out_ch.hit ? BARY_W'(qu) : '0;
  assign out_ch.bary_v       = out_ch.hit ? BARY_W'(qv) : '0;

`ifndef SYNTHESIS
  a_bary_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> (out_ch.bary_u <= BARY_ONE) && (out_ch.bary_v <= BARY_ONE))
    else $error("barycentric coordinate above one on a hit");

  a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |->
      ({1'b0, out_ch.bary_u} + {1'b0, out_ch.bary_v} <= {1'b0, BARY_ONE}))
    else $error("u plus v above one on a hit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(qt) && $stable(qu) && $stable(side_dly_r[DIV_LAT-1]))
    else $error("pipeline moved while stalled");
`endif
endmodule

[test/ray_triangle_intersection_test.sv]
`timescale 1ns / 100ps

module ray_triangle_intersection_test;
  import rti_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int ONE = 65536;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [31:0] vtx [9];
    logic [TAG_W-1:0]   tag;
  } triangle_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] t_dist;
    logic [BARY_W-1:0] u;
    logic [BARY_W-1:0] v;
    logic [TAG_W-1:0]  tag;
  } hit_t;

  logic clk;
  logic rst_n;

  rti_in_if  #(.CW(32)) in_ch ();
  rti_out_if            out_ch ();
  rti_cfg_if #(.DW(32)) cfg_ch ();

  ray_triangle_intersection #(.COORD_WIDTH(32)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ray as the block should hold it
  logic signed [31:0]    ray_org [3];
  logic signed [DIR_W-1:0] ray_dir [3];

  hit_t hits_due [$];
  int   burst_left;
  int   failures;
  int   stall_mode;
  int   stall_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic hit_t intersect_ray(triangle_t t);
    wide_t p0 [3];
    wide_t e1 [3];
    wide_t e2 [3];
    wide_t s [3];
    wide_t d [3];
    wide_t h [3];
    wide_t q [3];
    wide_t det, un, vn, tn, quo;
    hit_t r;
    for (int i = 0; i < 3; i++) begin
      p0[i] = wide_t'(t.vtx[i]);
      e1[i] = wide_t'(t.vtx[3+i]) - p0[i];
      e2[i] = wide_t'(t.vtx[6+i]) - p0[i];
      s[i]  = wide_t'(ray_org[i]) - p0[i];
      d[i]  = wide_t'(ray_dir[i]);
    end
    r = '{hit: 1'b0, t_dist: '0, u: '0, v: '0, tag: t.tag};
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    if (det == 0) return r;
    un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det < 0) begin
      det = -det;
      un  = -un;
      vn  = -vn;
      tn  = -tn;
    end
    if (un < 0 || un > det) return r;
    if (vn < 0 || un + vn > det) return r;
    if (tn <= 0) return r;
    r.hit = 1'b1;
    quo = (tn <<< T_SHIFT) / det;
    r.t_dist = (quo > wide_t'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
    quo = (un <<< 16) / det;
    r.u = quo[BARY_W-1:0];
    quo = (vn <<< 16) / det;
    r.v = quo[BARY_W-1:0];
    return r;
  endfunction

  // result side: stall pattern is redrawn at random among always ready, random ready and a periodic pattern
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (stall_count % 8) > 2;
    endcase
  end

  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_due.size() == 0) begin
        $error("result beat with nothing expected, tag %0d", out_ch.tag_out);
        failures++;
      end else begin
        want = hits_due.pop_front();
        if (out_ch.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_ch.hit);
          failures++;
        end
        if (out_ch.hit_distance !== want.t_dist) begin
          $error("hit_distance: expected %0d, got %0d", want.t_dist, out_ch.hit_distance);
          failures++;
        end
        if (out_ch.bary_u !== want.u) begin
          $error("bary_u: expected %0d, got %0d", want.u, out_ch.bary_u);
          failures++;
        end
        if (out_ch.bary_v !== want.v) begin
          $error("bary_v: expected %0d, got %0d", want.v, out_ch.bary_v);
          failures++;
        end
        if (out_ch.tag_out !== want.tag) begin
          $error("tag_out: expected %0d, got %0d", want.tag, out_ch.tag_out);
          failures++;
        end
      end
    end
  end

  task automatic send_triangle(triangle_t t);
    in_ch.valid   <= 1'b1;
    in_ch.v0_x    <= t.vtx[0];
    in_ch.v0_y    <= t.vtx[1];
    in_ch.v0_z    <= t.vtx[2];
    in_ch.v1_x    <= t.vtx[3];
    in_ch.v1_y    <= t.vtx[4];
    in_ch.v1_z    <= t.vtx[5];
    in_ch.v2_x    <= t.vtx[6];
    in_ch.v2_y    <= t.vtx[7];
    in_ch.v2_z    <= t.vtx[8];
    in_ch.tri_tag <= t.tag;
    do @(posedge clk); while (!in_ch.ready);
    hits_due = {hits_due, intersect_ray(t)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < REG_DIR_X) ray_org[idx[1:0]] = data;
    else if (idx <= REG_DIR_Z) ray_dir[2'(idx - REG_DIR_X)] = data[DIR_W-1:0];
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    wait_idle();
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    // dropped by the block
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz);
    triangle_t t;
    t.vtx = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    t.tag = TAG_W'($urandom);
    return t;
  endfunction

  // triangle scattered around a point along the ray, so many of them are hit
  function automatic triangle_t ray_aimed_tri(int spread);
    triangle_t t;
    longint along;
    along = longint'($urandom_range(0, 1 << 22)) - (1 << 18);
    for (int k = 0; k < 9; k++)
      t.vtx[k] = 32'(longint'(ray_org[k%3]) + ((longint'(ray_dir[k%3]) * along) >>> 16)
                 + longint'($urandom_range(0, 2 * spread)) - spread);
    t.tag = TAG_W'($urandom);
    return t;
  endfunction

  function automatic triangle_t noise_tri();
    triangle_t t;
    for (int k = 0; k < 9; k++) t.vtx[k] = $urandom;
    t.tag = TAG_W'($urandom);
    return t;
  endfunction

  task automatic test_default_ray();
    triangle_t t;
    // plain hit at t = 5, then behind, on the origin plane and edges
    send_triangle(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    send_triangle(make_tri(-ONE, -ONE, -5*ONE, 2*ONE, -ONE, -5*ONE, -ONE, 2*ONE, -5*ONE));
    send_triangle(make_tri(-ONE, -ONE, 0, 2*ONE, -ONE, 0, -ONE, 2*ONE, 0));
    send_triangle(make_tri(0, 0, 3*ONE, ONE, 0, 3*ONE, 0, ONE, 3*ONE));
    send_triangle(make_tri(-ONE, 0, 3*ONE, 0, 0, 3*ONE, -ONE, ONE, 3*ONE));
    send_triangle(make_tri(-ONE, -ONE, 3*ONE, 0, 0, 3*ONE, -2*ONE, 0, 3*ONE));
    send_triangle(make_tri(ONE, ONE, 2*ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE, 2*ONE));
    // tiny t, reported as the smallest nonzero distance
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 1, -ONE, ONE, 1));
    // degenerate and parallel
    send_triangle(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_triangle(make_tri(0, -ONE, 0, 0, ONE, 0, 0, 0, 4*ONE));
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, ONE, 3*ONE, 3*ONE, 3*ONE, 5*ONE));
    // field extremes
    t = make_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    t.tag = '0;
    send_triangle(t);
    t = make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    t.tag = '1;
    send_triangle(t);
    send_triangle(make_tri(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                           32'h7fffffff));
    send_triangle(make_tri(32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0,
                           32'h80000000, 32'h7fffffff, 32'h80000000));
  endtask

  task automatic test_long_ray();
    // tiny direction makes t overflow
    set_ray(0, 0, 0, 0, 0, 1);
    send_triangle(make_tri(-ONE, -ONE, 32'h7fff0000, ONE, -ONE, 32'h7fff0000,
                           -ONE, ONE, 32'h7fff0000));
    send_triangle(make_tri(-ONE, -ONE, 100*ONE, ONE, -ONE, 100*ONE, -ONE, ONE, 100*ONE));
    // extreme origin and direction
    set_ray(32'h80000000, 32'h7fffffff, 32'h80000000, -ONE, ONE, -ONE);
    send_triangle(make_tri(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                           32'h80000000));
    send_triangle(ray_aimed_tri(1 << 20));
    // zero direction never hits
    set_ray(ONE, ONE, ONE, 0, 0, 0);
    send_triangle(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
  endtask

  task automatic test_random_rays();
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_ray(0, 0, 0, ONE, 0, 0);
        1: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1ffff, 32'h20000, ONE);
        default: set_ray($urandom_range(0, 1 << 27) - (1 << 26),
                         $urandom_range(0, 1 << 27) - (1 << 26),
                         $urandom_range(0, 1 << 27) - (1 << 26),
                         $urandom_range(0, 2 * ONE) - ONE, $urandom_range(0, 2 * ONE) - ONE,
                         $urandom_range(0, 2 * ONE) - ONE);
      endcase
      for (int n = 0; n < 78; n++) begin
        if ($urandom_range(0, 4) == 0) send_triangle(noise_tri());
        else send_triangle(ray_aimed_tri(1 << $urandom_range(8, 24)));
      end
    end
  endtask

  initial begin
    failures     = 0;
    burst_left   = 0;
    stall_mode   = 0;
    stall_count  = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.v0_x   = '0;
    in_ch.v0_y   = '0;
    in_ch.v0_z   = '0;
    in_ch.v1_x   = '0;
    in_ch.v1_y   = '0;
    in_ch.v1_z   = '0;
    in_ch.v2_x   = '0;
    in_ch.v2_y   = '0;
    in_ch.v2_z   = '0;
    in_ch.tri_tag = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORG_X;
    cfg_ch.data  = '0;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, DIR_Z_RESET};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_ray();
    test_long_ray();
    test_random_rays();

    wait_idle();
    repeat (50) @(posedge clk);
    if (failures == 0 && hits_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
